// File: rtl/sds_pkg.sv
// Shared types, sizes, register indexes and reset values of the diffusion stencil block.
package sds_pkg;

	// Grid geometry limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MASK_SIZE  = 3;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WU_W   = $clog2(MAX_WIDTH + 1);
	localparam int HU_W   = $clog2(MAX_HEIGHT + 1);
	localparam int GEOM_W = 11;

	// Arithmetic widths
	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int COLSUM_W = PROD_W + 2;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_MIDDLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_BOTTOM = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN   = 3'd5;

	localparam logic [GEOM_W-1:0]     RST_GRID_WIDTH  = 11'd1024;
	localparam logic [GEOM_W-1:0]     RST_GRID_HEIGHT = 11'd1024;
	localparam logic [CFG_DATA_W-1:0] RST_MASK_TOP    = 48'h0000_0100_0000;
	localparam logic [CFG_DATA_W-1:0] RST_MASK_MIDDLE = 48'h0100_FC00_0100;
	localparam logic [CFG_DATA_W-1:0] RST_MASK_BOTTOM = 48'h0000_0100_0000;
	localparam logic [15:0]           RST_STEP_GAIN   = 16'd6554;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	// one window column, index 0 is the oldest row
	typedef logic [MASK_SIZE-1:0][SAMPLE_W-1:0] column_t;
	typedef logic signed [COLSUM_W-1:0] colsum_t;

	typedef struct packed {
		logic load;  // shift a new column into the window
		logic adv;   // pipeline moves one stage
	} cell_ctrl_t;

endpackage

// File: rtl/sds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/sds_cell.sv
// One window column cell: holds three samples, multiplies by its mask column, sums the column.
module sds_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sds_pkg::cell_ctrl_t ctrl,
	input  sds_pkg::column_t    col_in,
	input  sds_pkg::column_t    coef,
	output sds_pkg::column_t    col_out,
	output sds_pkg::colsum_t    colsum_s4
);

	sds_pkg::column_t col_q;
	logic signed [sds_pkg::PROD_W-1:0] prod_s3 [sds_pkg::MASK_SIZE];

	// window column, handed on to the left neighbour on each load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctrl.load) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			for (int i = 0; i < sds_pkg::MASK_SIZE; i++) begin
				prod_s3[i] <= $signed(coef[i]) * $signed(col_q[i]);
			end
			colsum_s4 <= sds_pkg::colsum_t'(prod_s3[0]) + sds_pkg::colsum_t'(prod_s3[1])
				+ sds_pkg::colsum_t'(prod_s3[2]);
		end
	end

endmodule

// File: rtl/stencil_diffusion_step.sv
// Top level of the streaming 3x3 stencil explicit-Euler diffusion step.
//
// Samples (signed Q2.14) stream in raster order, one item per clock when the result side keeps
// up; each interior cell yields new = centre + step_gain * laplacian and the laplacian itself,
// with tlast on the frame's last interior cell, registered in stages 1 to 6 and the result
// register. The rate of one item per cycle is set by the single line-store RAM, read once
// and written once per item, and by a row of three column cells that shift every item. A
// stalled result holds the whole pipeline, so no item is taken while the output waits.
// Configuration writes are always taken; change registers only while the block is idle.
// Writing the width or height restarts the frame.
module stencil_diffusion_step (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [15:0]                      s_axis_tdata,   // [15:0] concentration
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [39:0]                      m_axis_tdata,   // [15:0] new_concentration,
	                                                         // [39:16] laplacian
	output logic                             m_axis_tlast,   // frame_last
	// register writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sds_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int ACC_W  = sds_pkg::COLSUM_W + 2;
	localparam int RND_W  = ACC_W - 8;
	localparam int LAP_W  = 24;
	localparam int GPR_W  = LAP_W + 17;
	localparam int UPD_W  = GPR_W + 1;
	localparam int URND_W = UPD_W - 16;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [UPD_W-1:0] upd_t;

	// ---------------------------------------------------------------- registers
	logic [sds_pkg::GEOM_W-1:0]     grid_width_q, grid_height_q;
	logic [sds_pkg::CFG_DATA_W-1:0] mask_top_q, mask_mid_q, mask_bot_q;
	logic [15:0]                    step_gain_q;
	logic                           cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= sds_pkg::RST_GRID_WIDTH;
			grid_height_q <= sds_pkg::RST_GRID_HEIGHT;
			mask_top_q    <= sds_pkg::RST_MASK_TOP;
			mask_mid_q    <= sds_pkg::RST_MASK_MIDDLE;
			mask_bot_q    <= sds_pkg::RST_MASK_BOTTOM;
			step_gain_q   <= sds_pkg::RST_STEP_GAIN;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				sds_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data[sds_pkg::GEOM_W-1:0];
				sds_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data[sds_pkg::GEOM_W-1:0];
				sds_pkg::REG_MASK_TOP:    mask_top_q    <= cfg_data;
				sds_pkg::REG_MASK_MIDDLE: mask_mid_q    <= cfg_data;
				sds_pkg::REG_MASK_BOTTOM: mask_bot_q    <= cfg_data;
				sds_pkg::REG_STEP_GAIN:   step_gain_q   <= cfg_data[15:0];
				default: ;  // unmapped index, ignored
			endcase
		end
	end

	// geometry in use, clamped to the supported range
	logic [sds_pkg::WU_W-1:0] wu;
	logic [sds_pkg::HU_W-1:0] hu;

	always_comb begin
		if (grid_width_q < 3) begin
			wu = sds_pkg::WU_W'(3);
		end else if (32'(grid_width_q) > sds_pkg::MAX_WIDTH) begin
			wu = sds_pkg::WU_W'(sds_pkg::MAX_WIDTH);
		end else begin
			wu = sds_pkg::WU_W'(grid_width_q);
		end
		if (grid_height_q < 3) begin
			hu = sds_pkg::HU_W'(3);
		end else if (32'(grid_height_q) > sds_pkg::MAX_HEIGHT) begin
			hu = sds_pkg::HU_W'(sds_pkg::MAX_HEIGHT);
		end else begin
			hu = sds_pkg::HU_W'(grid_height_q);
		end
	end

	// ---------------------------------------------------------------- flow control
	// Every stage moves together; the only place an item can wait is the result register.
	logic adv, accept;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// ---------------------------------------------------------------- raster counters
	logic [sds_pkg::COL_W-1:0] col_q;
	logic [sds_pkg::ROW_W-1:0] row_q;
	logic                      col_end, row_end, geom_wr;

	assign col_end = (32'(col_q) + 1) == 32'(wu);
	assign row_end = (32'(row_q) + 1) == 32'(hu);
	assign geom_wr = cfg_wr &&
		(cfg_index == sds_pkg::REG_GRID_WIDTH || cfg_index == sds_pkg::REG_GRID_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (geom_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- stage 1: line store read
	logic                      v_s1, int_s1, last_s1;
	sds_pkg::sample_t          x_s1;
	logic [sds_pkg::COL_W-1:0] addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= s_axis_tdata;
			addr_s1 <= col_q;
			int_s1  <= row_q >= 2 && col_q >= 2;
			last_s1 <= row_end && col_end;
		end
	end

	// Each entry holds both older rows of one column: low half row r-2, high half row r-1.
	// Consecutive items hit different columns, so the write-back never meets the next read.
	logic                                ram_we;
	logic [2*sds_pkg::SAMPLE_W-1:0]      ram_rd;

	assign ram_we = adv && v_s1;

	sds_ram #(
		.WIDTH(2 * sds_pkg::SAMPLE_W),
		.DEPTH(sds_pkg::MAX_WIDTH)
	) u_line_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(addr_s1),
		.wr_data({x_s1, ram_rd[2*sds_pkg::SAMPLE_W-1:sds_pkg::SAMPLE_W]}),
		.rd_en  (accept),
		.rd_addr(col_q),
		.rd_data(ram_rd)
	);

	// ---------------------------------------------------------------- window cells
	// Cell 2 takes the fresh column, cells 1 and 0 take their right neighbour's column.
	sds_pkg::cell_ctrl_t ctrl;
	sds_pkg::column_t    new_col, col1, col2;
	sds_pkg::column_t    coef0, coef1, coef2;
	sds_pkg::colsum_t    cs0_s4, cs1_s4, cs2_s4;

	assign ctrl.load = adv && v_s1;
	assign ctrl.adv  = adv;
	assign new_col   = {x_s1, ram_rd[2*sds_pkg::SAMPLE_W-1:sds_pkg::SAMPLE_W],
		ram_rd[sds_pkg::SAMPLE_W-1:0]};

	// mask column k of each row sits at bits 16k upwards
	assign coef0 = {mask_bot_q[15:0],  mask_mid_q[15:0],  mask_top_q[15:0]};
	assign coef1 = {mask_bot_q[31:16], mask_mid_q[31:16], mask_top_q[31:16]};
	assign coef2 = {mask_bot_q[47:32], mask_mid_q[47:32], mask_top_q[47:32]};

	sds_cell u_cell0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.col_in   (col1),
		.coef     (coef0),
		.col_out  (),
		.colsum_s4(cs0_s4)
	);

	sds_cell u_cell1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.col_in   (col2),
		.coef     (coef1),
		.col_out  (col1),
		.colsum_s4(cs1_s4)
	);

	sds_cell u_cell2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.col_in   (new_col),
		.coef     (coef2),
		.col_out  (col2),
		.colsum_s4(cs2_s4)
	);

	// ---------------------------------------------------------------- stages 2 to 6
	logic             v_s2, v_s3, v_s4, v_s5, v_s6;
	logic             last_s2, last_s3, last_s4, last_s5, last_s6;
	sds_pkg::sample_t center_s3, center_s4, center_s5, center_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && int_s1;  // border cells drop out here
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 4: total, round half up to Q10.14, saturate
	acc_t                    acc;
	logic signed [RND_W-1:0] lap_rnd;
	logic signed [LAP_W-1:0] lap_sat;

	always_comb begin
		acc     = acc_t'(cs0_s4) + acc_t'(cs1_s4) + acc_t'(cs2_s4);
		lap_rnd = RND_W'((acc + acc_t'(128)) >>> 8);
		if (lap_rnd > RND_W'(8388607)) begin
			lap_sat = 24'sh7FFFFF;
		end else if (lap_rnd < -RND_W'(8388608)) begin
			lap_sat = 24'sh800000;
		end else begin
			lap_sat = lap_rnd[LAP_W-1:0];
		end
	end

	logic signed [LAP_W-1:0] lap_s5, lap_s6;
	logic signed [GPR_W-1:0] gprod_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2   <= last_s1;
			last_s3   <= last_s2;
			last_s4   <= last_s3;
			last_s5   <= last_s4;
			last_s6   <= last_s5;
			center_s3 <= col1[1];
			center_s4 <= center_s3;
			center_s5 <= center_s4;
			center_s6 <= center_s5;
			lap_s5    <= lap_sat;
			lap_s6    <= lap_s5;
			gprod_s6  <= $signed({1'b0, step_gain_q}) * lap_s5;
		end
	end

	// stage 6: centre in Q.30 plus gain product, round half up to Q2.14, saturate
	upd_t                     upd;
	logic signed [URND_W-1:0] upd_rnd;
	logic signed [15:0]       upd_sat;

	always_comb begin
		upd     = (upd_t'(center_s6) <<< 16) + upd_t'(gprod_s6) + upd_t'(32768);
		upd_rnd = URND_W'(upd >>> 16);
		if (upd_rnd > URND_W'(32767)) begin
			upd_sat = 16'sh7FFF;
		end else if (upd_rnd < -URND_W'(32768)) begin
			upd_sat = 16'sh8000;
		end else begin
			upd_sat = upd_rnd[15:0];
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {lap_s6, upd_sat};
			m_axis_tlast <= last_s6;
		end
	end

	// ---------------------------------------------------------------- checks
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !accept)
		else $error("item accepted while result stalled");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(wu))
		else $error("column counter beyond row width");

	a_ram_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && accept) |-> (addr_s1 != col_q))
		else $error("line store read and write on the same column");

	a_geom_restart: assert property (@(posedge clk) disable iff (!arst_n)
		geom_wr |=> (col_q == '0 && row_q == '0))
		else $error("frame not restarted after geometry write");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the streaming 3x3 stencil diffusion step.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	// pipeline is seven deep; give it room before touching registers or ending
	localparam int SETTLE_CYCLES = 20;
	// random part of the run: total items, and the most items in one phase
	localparam int RANDOM_ITEMS = 240;
	localparam int PHASE_ITEMS_MAX = 96;

	// one interior-cell update as it should leave the block
	typedef struct {
		logic [15:0] new_conc;
		logic [23:0] lap;
		logic        last;
	} cell_result_t;

	// ---------------------------------------------------------------- DUT side
	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [15:0]                    s_axis_tdata = '0;   // [15:0] concentration
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [39:0]                    m_axis_tdata;        // [15:0] new_concentration,
	                                                     // [39:16] laplacian
	logic                           m_axis_tlast;        // frame_last
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [sds_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sds_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	stencil_diffusion_step dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// -------------------------------------------------------- predictor state
	// mirrors of the registers
	logic [sds_pkg::GEOM_W-1:0]     width_reg;
	logic [sds_pkg::GEOM_W-1:0]     height_reg;
	logic [sds_pkg::CFG_DATA_W-1:0] mask_reg [3];
	logic [15:0]                    gain_reg;
	// two line stores back to back (line 0 = row r-2, line 1 = row r-1) and the 3x3 window
	sds_pkg::sample_t               line_buf [2*sds_pkg::MAX_WIDTH];
	sds_pkg::sample_t               win [9];
	int unsigned                    col_pos;
	int unsigned                    row_pos;

	cell_result_t                   expected_cells [$];
	logic [15:0]                    sample_q [$];

	// stimulus shaping, changed only between phases
	int unsigned                    src_idle_pct = 0;
	int unsigned                    sink_stall_pct = 0;

	// bookkeeping
	bit                             in_taken = 1'b0;
	int unsigned                    mismatches = 0;
	int unsigned                    items_in = 0;
	int unsigned                    cells_out = 0;
	int unsigned                    cfg_writes = 0;
	int unsigned                    cycle_count = 0;

	function automatic int unsigned clamp_dim(input logic [sds_pkg::GEOM_W-1:0] v,
		input int unsigned top);
		if (v < 3)
			return 3;
		if (v > top)
			return top;
		return 32'(v);
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 40)
			$display("[%0t] MISMATCH cell %0d: %s", $realtime, cells_out, what);
		mismatches++;
	endtask

	task automatic apply_reg(input logic [sds_pkg::CFG_IDX_W-1:0] idx,
		input logic [sds_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			sds_pkg::REG_GRID_WIDTH: begin
				width_reg = val[sds_pkg::GEOM_W-1:0];
				col_pos = 0;
				row_pos = 0;
			end
			sds_pkg::REG_GRID_HEIGHT: begin
				height_reg = val[sds_pkg::GEOM_W-1:0];
				col_pos = 0;
				row_pos = 0;
			end
			sds_pkg::REG_MASK_TOP:    mask_reg[0] = val;
			sds_pkg::REG_MASK_MIDDLE: mask_reg[1] = val;
			sds_pkg::REG_MASK_BOTTOM: mask_reg[2] = val;
			sds_pkg::REG_STEP_GAIN:   gain_reg = val[15:0];
			default: ;  // unknown index: no effect
		endcase
	endtask

	// Advance the line stores and window by one sample; queue the update of the cell one row
	// up and one column left when its neighbourhood is complete.
	task automatic diffuse_sample(input logic [15:0] raw);
		int unsigned      w, h, c, r;
		int               rr, cc;
		sds_pkg::sample_t up2, up1, coef;
		longint           acc, lap, upd;
		cell_result_t     upd_res;
		w = clamp_dim(width_reg, sds_pkg::MAX_WIDTH);
		h = clamp_dim(height_reg, sds_pkg::MAX_HEIGHT);
		c = (col_pos >= w) ? 0 : col_pos;
		r = (row_pos >= h) ? 0 : row_pos;

		up2 = line_buf[c];
		up1 = line_buf[sds_pkg::MAX_WIDTH + c];
		for (rr = 0; rr < 3; rr++) begin
			win[rr*3 + 0] = win[rr*3 + 1];
			win[rr*3 + 1] = win[rr*3 + 2];
		end
		win[2] = up2;
		win[5] = up1;
		win[8] = raw;
		line_buf[c] = up1;
		line_buf[sds_pkg::MAX_WIDTH + c] = raw;

		if (r >= 2 && c >= 2) begin
			acc = 0;
			for (rr = 0; rr < 3; rr++)
				for (cc = 0; cc < 3; cc++) begin
					coef = mask_reg[rr][16*cc +: 16];
					acc += longint'(coef) * longint'(win[rr*3 + cc]);
				end
			// Q10.22 -> Q10.14, round half up, then clip to 24 bits
			lap = (acc + 128) >>> 8;
			if (lap > 8388607)
				lap = 8388607;
			else if (lap < -8388608)
				lap = -8388608;
			// centre in Q.30 plus gain * laplacian, back to Q2.14
			upd = longint'(win[4]) * 65536 + longint'(gain_reg) * lap;
			upd = (upd + 32768) >>> 16;
			if (upd > 32767)
				upd = 32767;
			else if (upd < -32768)
				upd = -32768;
			upd_res.new_conc = upd[15:0];
			upd_res.lap = lap[23:0];
			upd_res.last = (r == h - 1) && (c == w - 1);
			expected_cells.push_back(upd_res);
		end

		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	// ----------------------------------------------------------------- driver
	// Inputs move on the falling edge. A held item stays until its handshake; a new item is
	// offered only when the sender is not idling this cycle.
	always @(negedge clk) begin : drive
		logic        nxt_valid;
		logic [15:0] nxt_data;
		nxt_valid = s_axis_tvalid;
		nxt_data = s_axis_tdata;
		if (!s_axis_tvalid || in_taken) begin
			nxt_valid = 1'b0;
			if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt_data = sample_q.pop_front();
				nxt_valid = 1'b1;
			end
		end
		s_axis_tvalid <= nxt_valid;
		s_axis_tdata <= nxt_data;
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// ---------------------------------------------------------------- monitor
	// Everything is sampled at the rising edge: register writes and accepted samples feed the
	// predictor, accepted results are checked against the oldest prediction.
	always @(posedge clk) begin : observe
		cell_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_index, cfg_data);
				cfg_writes++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				diffuse_sample(s_axis_tdata);
				items_in++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_cells.size() == 0) begin
					report_mismatch($sformatf("unexpected result data=%h last=%b",
						m_axis_tdata, m_axis_tlast));
				end else begin
					want = expected_cells.pop_front();
					if (m_axis_tdata[15:0] !== want.new_conc)
						report_mismatch($sformatf("new_concentration %h, want %h",
							m_axis_tdata[15:0], want.new_conc));
					if (m_axis_tdata[39:16] !== want.lap)
						report_mismatch($sformatf("laplacian %h, want %h",
							m_axis_tdata[39:16], want.lap));
					if (m_axis_tlast !== want.last)
						report_mismatch($sformatf("frame_last %b, want %b",
							m_axis_tlast, want.last));
				end
				cells_out++;
			end
		end
		in_taken <= arst_n && s_axis_tvalid && s_axis_tready;
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d cells still owed", cycle_count,
				expected_cells.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// -------------------------------------------------------------- stimulus
	task automatic write_reg(input logic [sds_pkg::CFG_IDX_W-1:0] idx,
		input logic [sds_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait for the pipeline to empty, then let any tail of work settle
	task automatic drain();
		while (sample_q.size() != 0 || s_axis_tvalid || expected_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// four idling styles taken in turn: none, sender gaps, receiver stalls, both
	task automatic set_idling(input int unsigned k);
		case (k % 4)
			0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
			default: begin src_idle_pct = 21; sink_stall_pct = 21; end
		endcase
	endtask

	// sample flavours: full range, small values that rarely saturate, or rail values
	function automatic logic [15:0] rand_sample(input int unsigned flavour);
		case (flavour)
			1: return 16'($urandom_range(1023)) - 16'd512;
			2: return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic push_samples(input int unsigned n, input int unsigned flavour);
		repeat (n) sample_q.push_back(rand_sample(flavour));
	endtask

	// three Q8.8 coefficients, mixing rails, zero, unity and random values
	function automatic logic [sds_pkg::CFG_DATA_W-1:0] pick_mask();
		logic [sds_pkg::CFG_DATA_W-1:0] m;
		int                             i;
		for (i = 0; i < 3; i++)
			case ($urandom_range(5))
				0: m[16*i +: 16] = 16'h8000;
				1: m[16*i +: 16] = 16'h7FFF;
				2: m[16*i +: 16] = 16'h0000;
				3: m[16*i +: 16] = 16'h0100;
				4: m[16*i +: 16] = 16'($urandom_range(2047)) - 16'd1024;
				default: m[16*i +: 16] = 16'($urandom());
			endcase
		return m;
	endfunction

	initial begin : stimulus
		int unsigned                    phase, rand_items, n, w, h, flavour;
		logic [sds_pkg::CFG_DATA_W-1:0] junk;
		logic [15:0]                    spot [9];

		width_reg = sds_pkg::RST_GRID_WIDTH;
		height_reg = sds_pkg::RST_GRID_HEIGHT;
		mask_reg[0] = sds_pkg::RST_MASK_TOP;
		mask_reg[1] = sds_pkg::RST_MASK_MIDDLE;
		mask_reg[2] = sds_pkg::RST_MASK_BOTTOM;
		gain_reg = sds_pkg::RST_STEP_GAIN;
		foreach (line_buf[i]) line_buf[i] = '0;
		foreach (win[i]) win[i] = '0;
		col_pos = 0;
		row_pos = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: the start of the first row of a 1024 wide grid, all border cells,
		// so nothing may come out.
		push_samples(40, 0);
		drain();

		// Directed: 3x3 frames (width and height written below the minimum), rails throughout.
		write_reg(sds_pkg::REG_GRID_WIDTH, 48'd1);
		write_reg(sds_pkg::REG_GRID_HEIGHT, 48'd2);
		write_reg(sds_pkg::REG_MASK_TOP, 48'h7FFF_7FFF_7FFF);
		write_reg(sds_pkg::REG_MASK_MIDDLE, 48'h7FFF_7FFF_7FFF);
		write_reg(sds_pkg::REG_MASK_BOTTOM, 48'h7FFF_7FFF_7FFF);
		write_reg(sds_pkg::REG_STEP_GAIN, 48'hFFFF);
		// all positive rail: laplacian and update clip high; then negative rail clips low
		repeat (9) sample_q.push_back(16'h7FFF);
		repeat (9) sample_q.push_back(16'h8000);
		drain();
		// unused register indexes must leave everything alone
		write_reg(3'd6, 48'({$urandom(), $urandom()}));
		write_reg(3'd7, 48'({$urandom(), $urandom()}));
		write_reg(sds_pkg::REG_GRID_WIDTH, 48'd0);
		write_reg(sds_pkg::REG_MASK_TOP, 48'h0001_8000_7FFF);
		write_reg(sds_pkg::REG_MASK_MIDDLE, sds_pkg::RST_MASK_MIDDLE);
		write_reg(sds_pkg::REG_MASK_BOTTOM, 48'h8000_0100_7FFF);
		write_reg(sds_pkg::REG_STEP_GAIN, 48'h0);
		// zero gain: the update is the centre sample itself
		spot = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h4000,
			16'h8000, 16'hC000, 16'h0001, 16'h0000};
		foreach (spot[i]) sample_q.push_back(spot[i]);
		drain();

		// Geometry above the limits: width 1025 runs as 1024 (first row only, no results),
		// height 2047 runs as 1024 (a narrow grid must not wrap early).
		set_idling(1);
		write_reg(sds_pkg::REG_MASK_TOP, sds_pkg::RST_MASK_TOP);
		write_reg(sds_pkg::REG_MASK_BOTTOM, sds_pkg::RST_MASK_BOTTOM);
		write_reg(sds_pkg::REG_STEP_GAIN, 48'hFFFF);
		write_reg(sds_pkg::REG_GRID_WIDTH, 48'd1025);
		write_reg(sds_pkg::REG_GRID_HEIGHT, 48'd3);
		push_samples(64, 1);
		drain();
		set_idling(2);
		write_reg(sds_pkg::REG_GRID_WIDTH, 48'd3);
		write_reg(sds_pkg::REG_GRID_HEIGHT, 48'd2047);
		push_samples(120, 0);
		drain();

		// Random phases. Mostly whole frames after a geometry write; sometimes a frame is cut
		// short, or carries on across a phase boundary with only the mask or gain changed.
		rand_items = 0;
		phase = 0;
		w = 3;
		h = 1024;
		while (rand_items < RANDOM_ITEMS) begin
			set_idling(phase);
			if (phase == 0 || $urandom_range(3) != 0) begin
				if ($urandom_range(7) == 0) begin
					w = $urandom_range(32, 13);
					h = 3;
				end else begin
					w = $urandom_range(12, 3);
					h = $urandom_range(6, 3);
				end
				// occasional junk above the 11 register bits, or a width below the minimum
				junk = 48'({$urandom(), $urandom()});
				junk[sds_pkg::GEOM_W-1:0] = sds_pkg::GEOM_W'(w);
				if ($urandom_range(9) == 0) begin
					junk[sds_pkg::GEOM_W-1:0] = sds_pkg::GEOM_W'($urandom_range(2));
					w = 3;
				end
				write_reg(sds_pkg::REG_GRID_WIDTH, ($urandom_range(3) == 0) ? junk : 48'(w));
				write_reg(sds_pkg::REG_GRID_HEIGHT, 48'(h));
				n = ($urandom_range(4) == 0) ? $urandom_range(w * h, 1) :
					w * h * $urandom_range(2, 1);
			end else begin
				n = $urandom_range(w * h, 1);
			end
			if (n > PHASE_ITEMS_MAX)
				n = PHASE_ITEMS_MAX;
			if (phase == 0 || $urandom_range(1) != 0) begin
				write_reg(sds_pkg::REG_MASK_TOP, pick_mask());
				write_reg(sds_pkg::REG_MASK_MIDDLE, pick_mask());
				write_reg(sds_pkg::REG_MASK_BOTTOM, pick_mask());
			end
			if ($urandom_range(2) == 0)
				case ($urandom_range(3))
					0: write_reg(sds_pkg::REG_STEP_GAIN, 48'h0);
					1: write_reg(sds_pkg::REG_STEP_GAIN, 48'hFFFF);
					default: write_reg(sds_pkg::REG_STEP_GAIN, 48'($urandom_range(65535)));
				endcase
			flavour = $urandom_range(5);
			flavour = (flavour >= 3) ? 0 : flavour;
			push_samples(n, flavour);
			rand_items += n;
			phase++;
			drain();
		end

		$display("Covered %0d samples, %0d cell updates, %0d register writes over %0d random phases",
			items_in, cells_out, cfg_writes, phase);
		$display("Grids from 3x3 up to 32 wide, short runs on over-range geometry, rail masks and gains");
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
